@@ rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Types and character codes shared by the calculator token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		KIND_NUMBER   = 3'd0,
		KIND_SYMBOL   = 3'd1,
		KIND_OPERATOR = 3'd2,
		KIND_NEWLINE  = 3'd3,
		KIND_END      = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
	} chr_t;

	typedef struct packed {
		logic [7:0] token_char;
		kind_t      token_kind;
		logic       token_start;
		logic       token_end;
		logic       last_of_run;
	} tok_t;

	// results of one item: r0 always present, r1 when two is set
	typedef struct packed {
		logic two;
		tok_t r0;
		tok_t r1;
	} bundle_t;

endpackage

@@ rtl/cts_front.sv @@
// ----------------------------------------------------------------------------
// cts_front
// Classifies each character against the held one and forms its results.
// ----------------------------------------------------------------------------
module cts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  cts_pkg::chr_t    chr,
	output logic             push,
	output cts_pkg::bundle_t push_data
);
	import cts_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_FIRST = 3'd1,
		MODE_INT   = 3'd2,
		MODE_FRAC  = 3'd3,
		MODE_SYM   = 3'd4
	} mode_t;

	mode_t      mode_q;
	logic [7:0] held_q;

	mode_t      nxt_mode;
	logic [7:0] nxt_held;
	logic       a_v;
	logic       b_v;
	tok_t       a;
	tok_t       b;
	logic [7:0] c;
	logic       blank;
	logic       nl;
	logic       space;
	logic       fits;

	function automatic logic is_digit(input logic [7:0] x);
		return (x >= CH_0) && (x <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] x);
		return ((x >= CH_UA) && (x <= CH_UZ)) || ((x >= CH_LA) && (x <= CH_LZ));
	endfunction

	function automatic kind_t single_kind(input logic [7:0] x);
		kind_t k;
		if (is_digit(x)) k = KIND_NUMBER;
		else if (is_letter(x)) k = KIND_SYMBOL;
		else k = KIND_OPERATOR;
		return k;
	endfunction

	function automatic tok_t mk(input logic [7:0] ch, input kind_t k, input logic s,
			input logic e);
		tok_t t;
		t.token_char  = ch;
		t.token_kind  = k;
		t.token_start = s;
		t.token_end   = e;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	always_comb begin
		c        = chr.in_char;
		blank    = (c == CH_SPACE) || (c == CH_TAB);
		nl       = (c == CH_NL);
		space    = blank || nl;
		fits     = (held_q == CH_DOT) ? is_digit(c) : (is_digit(c) || (c == CH_DOT));
		a_v      = 1'b0;
		a        = mk(held_q, KIND_NUMBER, 1'b0, 1'b0);
		// start of a new token from this character
		b_v      = nl;
		b        = mk(CH_NL, KIND_NEWLINE, 1'b1, 1'b1);
		nxt_mode = space ? MODE_IDLE : MODE_FIRST;
		nxt_held = space ? held_q : c;
		if (chr.end_of_input) begin
			b_v      = 1'b1;
			b        = mk(CH_NUL, KIND_END, 1'b1, 1'b1);
			nxt_mode = MODE_IDLE;
			nxt_held = held_q;
			unique case (mode_q)
				MODE_FIRST: begin
					a_v = 1'b1;
					a   = mk(held_q, single_kind(held_q), 1'b1, 1'b1);
				end
				MODE_INT, MODE_FRAC: begin
					a_v = 1'b1;
					a   = mk(held_q, KIND_NUMBER, 1'b0, 1'b1);
				end
				MODE_SYM: begin
					a_v = 1'b1;
					a   = mk(held_q, KIND_SYMBOL, 1'b0, 1'b1);
				end
				default: a_v = 1'b0;
			endcase
		end else begin
			unique case (mode_q)
				MODE_FIRST: begin
					a_v = 1'b1;
					if (space) begin
						a = mk(held_q, single_kind(held_q), 1'b1, 1'b1);
					end else if (is_digit(held_q) || (held_q == CH_MINUS) ||
							(held_q == CH_DOT)) begin
						if (fits) begin
							a        = mk(held_q, KIND_NUMBER, 1'b1, 1'b0);
							b_v      = 1'b0;
							nxt_held = c;
							nxt_mode = ((held_q == CH_DOT) || (c == CH_DOT)) ?
								MODE_FRAC : MODE_INT;
						end else begin
							a = mk(held_q, KIND_NUMBER, 1'b1, 1'b1);
						end
					end else begin
						a        = mk(held_q, KIND_SYMBOL, 1'b1, 1'b0);
						b_v      = 1'b0;
						nxt_held = c;
						nxt_mode = MODE_SYM;
					end
				end
				MODE_INT, MODE_FRAC: begin
					a_v = 1'b1;
					if (is_digit(c)) begin
						a        = mk(held_q, KIND_NUMBER, 1'b0, 1'b0);
						b_v      = 1'b0;
						nxt_held = c;
						nxt_mode = mode_q;
					end else if ((c == CH_DOT) && (mode_q == MODE_INT)) begin
						a        = mk(held_q, KIND_NUMBER, 1'b0, 1'b0);
						b_v      = 1'b0;
						nxt_held = c;
						nxt_mode = MODE_FRAC;
					end else begin
						a = mk(held_q, KIND_NUMBER, 1'b0, 1'b1);
					end
				end
				MODE_SYM: begin
					a_v = 1'b1;
					if (space) begin
						a = mk(held_q, KIND_SYMBOL, 1'b0, 1'b1);
					end else begin
						a        = mk(held_q, KIND_SYMBOL, 1'b0, 1'b0);
						b_v      = 1'b0;
						nxt_held = c;
						nxt_mode = MODE_SYM;
					end
				end
				default: a_v = 1'b0;
			endcase
		end
	end

	always_comb begin
		push           = accept && (a_v || b_v);
		push_data.two  = a_v && b_v;
		push_data.r0   = a_v ? a : b;
		push_data.r1   = b;
		push_data.r0.last_of_run = !(a_v && b_v);
		push_data.r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= CH_NUL;
		end else if (accept) begin
			mode_q <= nxt_mode;
			held_q <= nxt_held;
		end
	end

`ifndef SYNTH
	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chr.end_of_input |=> mode_q == MODE_IDLE)
		else $error("scanner not idle after end of input");
`endif

endmodule

@@ rtl/cts_queue.sv @@
// ----------------------------------------------------------------------------
// cts_queue
// Small first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module cts_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cts_pkg::bundle_t push_data,
	input  logic             pop,
	output logic             not_full,
	output logic             not_empty,
	output cts_pkg::bundle_t head
);
	import cts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t       slots_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

@@ rtl/cts_back.sv @@
// ----------------------------------------------------------------------------
// cts_back
// Unpacks result bundles into single tokens behind an output register.
// ----------------------------------------------------------------------------
module cts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  cts_pkg::bundle_t head,
	output logic             pop,
	output logic             tok_valid,
	input  logic             tok_stall,
	output cts_pkg::tok_t    tok
);
	import cts_pkg::*;

	logic out_valid_q;
	tok_t out_q;
	logic sec_valid_q;
	tok_t sec_q;
	logic room;

	assign room      = !out_valid_q || !tok_stall;
	assign pop       = room && !sec_valid_q && not_empty;
	assign tok_valid = out_valid_q;
	assign tok       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (room) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= not_empty;
				sec_valid_q <= not_empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (room) begin
			if (sec_valid_q) begin
				out_q <= sec_q;
			end else if (not_empty) begin
				out_q <= head.r0;
				sec_q <= head.r1;
			end
		end
	end

`ifndef SYNTH
	a_second_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> out_valid_q)
		else $error("second token pending without first");
`endif

endmodule

@@ rtl/calculator_token_scanner.sv @@
// ----------------------------------------------------------------------------
// calculator_token_scanner
// Splits a character stream into calculator tokens, one token character per
// output item, with kind and first/last marks.
// ----------------------------------------------------------------------------
//  channel  valid      stall      payload  dir
//  chr      chr_valid  chr_stall  chr      in   one character or end of input
//  tok      tok_valid  tok_stall  tok      out  one token character
//
//  a character is taken every cycle while the queue has a free slot
//  each item gives up to two tokens, sent at one per cycle by the back end while tok_stall is low
//  an item's first token passes through a queue slot, then the output register, before it is on tok
//  reset: scanner idle, queue and output register empty
//  chr_stall rises only when the DEPTH-entry queue fills
// ----------------------------------------------------------------------------
module calculator_token_scanner #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          chr_valid,
	output logic          chr_stall,
	input  cts_pkg::chr_t chr,
	output logic          tok_valid,
	input  logic          tok_stall,
	output cts_pkg::tok_t tok
);
	import cts_pkg::*;

	logic    accept;
	logic    push;
	bundle_t push_data;
	logic    pop;
	logic    not_full;
	logic    not_empty;
	bundle_t head;

	assign chr_stall = !not_full;
	assign accept    = chr_valid && not_full;

	cts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.chr       (chr),
		.push      (push),
		.push_data (push_data)
	);

	cts_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_full  (not_full),
		.not_empty (not_empty),
		.head      (head)
	);

	cts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calculator token scanner. Characters go in
// through the chr channel, with random gaps on the sending side and random
// stalls on the receiving side. Every accepted character runs through a model
// of the scanner, which queues the token characters it should produce. Each
// token character that leaves the block is compared with the oldest queued
// one. Directed runs cover single characters, numbers, symbols, odd bytes and
// end of input. Random runs send mostly well-formed token streams with some
// noise, and one run holds off the output long enough to fill the block.
// ----------------------------------------------------------------------------
module tb;
	import cts_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned ITEM_TARGET = 1500;

	typedef enum logic [2:0] {
		SCAN_IDLE  = 3'd0,
		SCAN_FIRST = 3'd1,
		SCAN_INT   = 3'd2,
		SCAN_FRAC  = 3'd3,
		SCAN_SYM   = 3'd4
	} scan_t;

	logic clk = 1'b0;
	logic arst_n;
	logic chr_valid;
	logic chr_stall;
	chr_t chr_item;
	logic tok_valid;
	logic tok_stall;
	tok_t tok_item;

	// scanner model state
	scan_t      scan_st;
	logic [7:0] pend_ch;
	logic       pend_first;
	tok_t       run_toks [2];
	int         run_n;
	tok_t       token_q [$];

	int unsigned errors = 0;
	int unsigned cycle_cnt = 0;
	int unsigned items_sent = 0;
	bit          idle_on = 1'b1;
	bit          stall_on = 1'b1;
	bit          hold_req = 1'b0;

	calculator_token_scanner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return is_blank(c) || c == CH_NL;
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		if (is_digit(c))
			return KIND_NUMBER;
		if (is_letter(c))
			return KIND_SYMBOL;
		return KIND_OPERATOR;
	endfunction

	function automatic void emit_tok(logic [7:0] ch, kind_t k, logic s, logic e);
		run_toks[run_n] = '{token_char: ch, token_kind: k, token_start: s,
			token_end: e, last_of_run: 1'b0};
		run_n++;
	endfunction

	// a character arriving with nothing pending
	function automatic void open_token(logic [7:0] c);
		if (is_blank(c)) begin
			scan_st = SCAN_IDLE;
			pend_first = 1'b0;
		end else if (c == CH_NL) begin
			emit_tok(CH_NL, KIND_NEWLINE, 1'b1, 1'b1);
			scan_st = SCAN_IDLE;
			pend_first = 1'b0;
		end else begin
			pend_ch = c;
			pend_first = 1'b1;
			scan_st = SCAN_FIRST;
		end
	endfunction

	function automatic void hold_next(logic [7:0] c, scan_t m);
		pend_ch = c;
		pend_first = 1'b0;
		scan_st = m;
	endfunction

	function automatic void predict_tokens(chr_t it);
		logic [7:0] c;
		logic [7:0] h;
		bit         fits;
		c = it.in_char;
		h = pend_ch;
		run_n = 0;
		if (it.end_of_input) begin
			case (scan_st)
				SCAN_FIRST: emit_tok(h, single_kind(h), 1'b1, 1'b1);
				SCAN_INT, SCAN_FRAC: emit_tok(h, KIND_NUMBER, 1'b0, 1'b1);
				SCAN_SYM: emit_tok(h, KIND_SYMBOL, 1'b0, 1'b1);
				default: ;
			endcase
			emit_tok(CH_NUL, KIND_END, 1'b1, 1'b1);
			scan_st = SCAN_IDLE;
			pend_first = 1'b0;
		end else begin
			case (scan_st)
				SCAN_FIRST: begin
					if (is_space(c)) begin
						emit_tok(h, single_kind(h), 1'b1, 1'b1);
						open_token(c);
					end else if (is_digit(h) || h == CH_MINUS || h == CH_DOT) begin
						fits = (h == CH_DOT) ? is_digit(c) : (is_digit(c) || c == CH_DOT);
						if (fits) begin
							emit_tok(h, KIND_NUMBER, 1'b1, 1'b0);
							hold_next(c, (h == CH_DOT || c == CH_DOT) ? SCAN_FRAC : SCAN_INT);
						end else begin
							emit_tok(h, KIND_NUMBER, 1'b1, 1'b1);
							open_token(c);
						end
					end else begin
						emit_tok(h, KIND_SYMBOL, 1'b1, 1'b0);
						hold_next(c, SCAN_SYM);
					end
				end
				SCAN_INT, SCAN_FRAC: begin
					if (is_digit(c)) begin
						emit_tok(h, KIND_NUMBER, 1'b0, 1'b0);
						hold_next(c, scan_st);
					end else if (c == CH_DOT && scan_st == SCAN_INT) begin
						emit_tok(h, KIND_NUMBER, 1'b0, 1'b0);
						hold_next(c, SCAN_FRAC);
					end else begin
						emit_tok(h, KIND_NUMBER, 1'b0, 1'b1);
						open_token(c);
					end
				end
				SCAN_SYM: begin
					if (is_space(c)) begin
						emit_tok(h, KIND_SYMBOL, 1'b0, 1'b1);
						open_token(c);
					end else begin
						emit_tok(h, KIND_SYMBOL, 1'b0, 1'b0);
						hold_next(c, SCAN_SYM);
					end
				end
				default: open_token(c);
			endcase
		end
		if (run_n > 0)
			run_toks[run_n - 1].last_of_run = 1'b1;
		for (int i = 0; i < run_n; i++)
			token_q.push_back(run_toks[i]);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		errors++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	// input monitor first, then the output check
	always @(posedge clk) begin
		tok_t want;
		if (arst_n && chr_valid && !chr_stall)
			predict_tokens(chr_item);
		if (arst_n && tok_valid && !tok_stall) begin
			if (token_q.size() == 0) begin
				errors++;
				$display("[%0t] unexpected token item, char %0d", $time, tok_item.token_char);
			end else begin
				want = token_q.pop_front();
				if (tok_item.token_char !== want.token_char)
					report_mismatch("token_char", int'(tok_item.token_char),
						int'(want.token_char));
				if (tok_item.token_kind !== want.token_kind)
					report_mismatch("token_kind", int'(tok_item.token_kind),
						int'(want.token_kind));
				if (tok_item.token_start !== want.token_start)
					report_mismatch("token_start", int'(tok_item.token_start),
						int'(want.token_start));
				if (tok_item.token_end !== want.token_end)
					report_mismatch("token_end", int'(tok_item.token_end),
						int'(want.token_end));
				if (tok_item.last_of_run !== want.last_of_run)
					report_mismatch("last_of_run", int'(tok_item.last_of_run),
						int'(want.last_of_run));
			end
		end
	end

	// receiving side, with a long hold-off on request
	initial begin
		tok_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (int unsigned n = 0; n < HOLD_CYCLES; n++) begin
					tok_stall <= 1'b1;
					@(posedge clk);
				end
			end
			tok_stall <= stall_on && ($urandom_range(99) < 14);
		end
	end

	task automatic send_item(chr_t it);
		while (idle_on && $urandom_range(99) < 14) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_item <= it;
		@(posedge clk);
		while (chr_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_item('{in_char: c, end_of_input: 1'b0});
	endtask

	task automatic send_end(logic [7:0] junk);
		send_item('{in_char: junk, end_of_input: 1'b1});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic wait_drained();
		chr_valid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly well-formed token streams with random content, some noise
	task automatic send_token_stream(int unsigned count);
		string       ops;
		int unsigned r;
		ops = "+-*/%^=";
		while (items_sent < count) begin
			r = $urandom_range(99);
			if (r < 35) begin
				if ($urandom_range(1))
					send_char(CH_MINUS);
				repeat ($urandom_range(4)) send_char(8'(CH_0 + $urandom_range(9)));
				if ($urandom_range(1)) begin
					send_char(CH_DOT);
					repeat ($urandom_range(3)) send_char(8'(CH_0 + $urandom_range(9)));
				end
			end else if (r < 60) begin
				send_char($urandom_range(1) ? 8'(CH_UA + $urandom_range(25)) :
					8'(CH_LA + $urandom_range(25)));
				repeat ($urandom_range(4)) begin
					if ($urandom_range(3) == 0)
						send_char(8'($urandom_range(255)));
					else
						send_char(8'(CH_LA + $urandom_range(25)));
				end
			end else if (r < 75) begin
				send_char(ops[$urandom_range(ops.len() - 1)]);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
			end else if (r < 88) begin
				send_end(8'($urandom_range(255)));
			end else begin
				send_char(CH_NL);
			end
			repeat ($urandom_range(2)) send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
		end
	endtask

	task automatic test_single_chars();
		send_text("7 a\t+\n");
		send_char(8'hff);
		send_end(8'hff);
		wait_drained();
	endtask

	task automatic test_numbers_and_ends();
		send_text("-1.5xy");
		send_char(CH_NUL);
		send_end(8'h00);
		send_end(8'h5a);
		wait_drained();
	endtask

	task automatic test_dots_and_odd_bytes();
		send_text(".5.");
		send_char(8'h0d);
		send_text("9.");
		send_end(CH_SPACE);
		wait_drained();
	endtask

	task automatic test_random_stream();
		send_token_stream(ITEM_TARGET - 300);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		stall_on = 1'b0;
		send_token_stream(items_sent + 200);
		wait_drained();
		idle_on = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_output_hold_off();
		idle_on = 1'b0;
		hold_req = 1'b1;
		send_token_stream(items_sent + 60);
		idle_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		chr_valid = 1'b0;
		chr_item = '0;
		scan_st = SCAN_IDLE;
		pend_ch = CH_NUL;
		pend_first = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_chars();
		test_numbers_and_ends();
		test_dots_and_odd_bytes();
		test_random_stream();
		test_back_to_back();
		test_output_hold_off();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
